// File: rtl/slbc_pkg.sv
// Shared types and codes for the strided layout bounds checker.
// Holds the axis and result word layouts and the status codes.
// No dependencies.
package slbc_pkg;

  // One axis descriptor as it arrives on the input channel
  typedef struct packed {
    logic [63:0]        extent;
    logic signed [63:0] source_stride;
    logic signed [63:0] destination_stride;
    logic signed [63:0] source_base;
    logic signed [63:0] destination_base;
    logic [63:0]        source_capacity;
    logic [63:0]        destination_capacity;
    logic               last_axis;
  } in_word_t;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK            = 3'd0,
    STAT_COUNT_OVF     = 3'd1,
    STAT_SRC_PRECEDES  = 3'd2,
    STAT_SRC_OVERFLOW  = 3'd3,
    STAT_SRC_EXCEEDS   = 3'd4,
    STAT_DST_PRECEDES  = 3'd5,
    STAT_DST_OVERFLOW  = 3'd6,
    STAT_DST_EXCEEDS   = 3'd7
  } status_t;

  // One result as it leaves on the output channel
  typedef struct packed {
    status_t     status;
    logic [62:0] source_lowest;
    logic [62:0] source_highest;
    logic [62:0] destination_lowest;
    logic [62:0] destination_highest;
    logic [63:0] element_total;
  } out_word_t;

  // Sticky per-view error while axes accumulate
  typedef enum logic [1:0] {
    VERR_NONE     = 2'd0,
    VERR_PRECEDES = 2'd1,
    VERR_OVERFLOW = 2'd2
  } view_err_t;

  // Per-view verdict at the end of a layout
  typedef enum logic [1:0] {
    VF_OK       = 2'd0,
    VF_PRECEDES = 2'd1,
    VF_OVERFLOW = 2'd2,
    VF_EXCEEDS  = 2'd3
  } view_final_t;

  // Largest signed 64-bit address
  localparam logic [63:0] ADDR_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

// File: rtl/slbc_if.sv
// Valid/ready channel interfaces for the strided layout bounds checker.
// Depends on slbc_pkg for the word layouts.
interface slbc_in_if import slbc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slbc_out_if import slbc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/strided_layout_bounds_check.sv
// Top level of the strided layout bounds checker.
// Depends on slbc_pkg and the channel interfaces in slbc_if.sv.
//
// Takes one axis word per cycle unless a last axis waits for the result
// register, and gives one result word for each word marked last_axis. An
// accepted word passes an input register, a stage of 32x32 partial products for
// the two address spans, and the accumulation stage that also loads the result
// register. The one-word-per-cycle figure is set by the accumulation stage, where
// the running element count is multiplied by the extent and fed back in the same
// cycle, alongside the running low and high addresses. Words that are not last
// keep flowing while a result waits to be taken; a last axis waits in the
// accumulation stage until the result register is free. Status: 0 ok, 1 count
// overflow, 2/3/4 source precedes, overflows or exceeds its storage, 5/6/7 the
// same for the destination; bounds are zero on any error and the element total
// is zero on count overflow.
module strided_layout_bounds_check import slbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  slbc_in_if.sink     in_chan,
  slbc_out_if.source  out_chan
);

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
    view_err_t   err;
  } view_t;

  typedef struct packed {
    logic [63:0]       extent;
    logic              skip;
    logic              src_neg;
    logic              dst_neg;
    logic [3:0][63:0]  src_pp;
    logic [3:0][63:0]  dst_pp;
    logic [63:0]       source_base;
    logic [63:0]       destination_base;
    logic [63:0]       source_capacity;
    logic [63:0]       destination_capacity;
    logic              last_axis;
  } span_word_t;

  // 32x32 partial products of a 64x64 multiply: ll, lh, hl, hh
  function automatic logic [3:0][63:0] part_products(logic [63:0] x, logic [63:0] y);
    logic [3:0][63:0] pp;
    pp[0] = 64'(x[31:0])  * 64'(y[31:0]);
    pp[1] = 64'(x[31:0])  * 64'(y[63:32]);
    pp[2] = 64'(x[63:32]) * 64'(y[31:0]);
    pp[3] = 64'(x[63:32]) * 64'(y[63:32]);
    return pp;
  endfunction

  // Sum partial products into the full 128-bit product
  function automatic logic [127:0] sum_products(logic [3:0][63:0] pp);
    return {64'd0, pp[0]} + {32'd0, pp[1], 32'd0} + {32'd0, pp[2], 32'd0} + {pp[3], 64'd0};
  endfunction

  function automatic logic [63:0] abs_stride(logic [63:0] s);
    return s[63] ? (~s + 64'd1) : s;
  endfunction

  // Widen one view by (extent - 1) * |stride|
  function automatic view_t view_step(view_t cur, logic skip, logic neg, logic [127:0] prod);
    logic [63:0] mag;
    logic [63:0] hsum;
    view_t       nxt;
    nxt  = cur;
    mag  = prod[63:0];
    hsum = cur.high + mag;
    if (cur.err == VERR_NONE && !skip) begin
      priority if (prod[127:63] != '0) begin
        nxt.err = VERR_OVERFLOW;
      end else if (neg) begin
        if (mag > cur.low) nxt.err = VERR_PRECEDES;
        else nxt.low = cur.low - mag;
      end else if (hsum[63]) begin
        nxt.err = VERR_OVERFLOW;
      end else begin
        nxt.high = hsum;
      end
    end
    return nxt;
  endfunction

  // Verdict for one view at the end of a layout
  function automatic view_final_t view_final(logic empty, logic [63:0] base,
                                             logic [63:0] size, view_t v);
    view_final_t r;
    priority if (empty) begin
      if (base[63]) r = VF_PRECEDES;
      else if (base > size) r = VF_EXCEEDS;
      else r = VF_OK;
    end else if (v.err == VERR_PRECEDES) begin
      r = VF_PRECEDES;
    end else if (v.err == VERR_OVERFLOW) begin
      r = VF_OVERFLOW;
    end else if (v.high >= size) begin
      r = VF_EXCEEDS;
    end else begin
      r = VF_OK;
    end
    return r;
  endfunction

  // Pipeline registers
  logic        s1_v_r;
  in_word_t    s1_r;
  logic        s2_v_r;
  span_word_t  s2_r;
  span_word_t  s2_nxt;
  logic        out_valid_r;
  out_word_t   out_r;
  out_word_t   out_nxt;

  // Accumulation state
  logic        in_layout_r;
  logic [63:0] count_r;
  logic [63:0] count_nxt;
  logic        covf_r;
  logic        covf_nxt;
  view_t       src_r;
  view_t       src_nxt;
  view_t       dst_r;
  view_t       dst_nxt;
  logic [63:0] src_base_r;
  logic [63:0] dst_base_r;
  logic [63:0] src_size_r;
  logic [63:0] dst_size_r;

  // Handshake chain
  logic out_free;
  logic fire3;
  logic fire2;
  logic s1_load_ok;

  assign out_free   = !out_valid_r || out_chan.ready;
  assign fire3      = s2_v_r && (!s2_r.last_axis || out_free);
  assign fire2      = s1_v_r && (!s2_v_r || fire3);
  assign s1_load_ok = !s1_v_r || fire2;

  assign in_chan.ready  = s1_load_ok;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load_ok) begin
      s1_v_r <= in_chan.valid;
    end
    if (s1_load_ok && in_chan.valid) s1_r <= in_chan.data;
  end

  // Form the span partial products
  always_comb begin
    s2_nxt.extent               = s1_r.extent;
    s2_nxt.skip                 = (s1_r.extent <= 64'd1);
    s2_nxt.src_neg              = s1_r.source_stride[63];
    s2_nxt.dst_neg              = s1_r.destination_stride[63];
    s2_nxt.src_pp               = part_products(s1_r.extent - 64'd1,
                                                abs_stride(s1_r.source_stride));
    s2_nxt.dst_pp               = part_products(s1_r.extent - 64'd1,
                                                abs_stride(s1_r.destination_stride));
    s2_nxt.source_base          = s1_r.source_base;
    s2_nxt.destination_base     = s1_r.destination_base;
    s2_nxt.source_capacity      = s1_r.source_capacity;
    s2_nxt.destination_capacity = s1_r.destination_capacity;
    s2_nxt.last_axis            = s1_r.last_axis;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (!s2_v_r || fire3) begin
      s2_v_r <= s1_v_r;
    end
    if (fire2) s2_r <= s2_nxt;
  end

  // Accumulate one axis and build the result
  always_comb begin
    logic          first;
    logic [63:0]   src_base;
    logic [63:0]   dst_base;
    logic [63:0]   src_size;
    logic [63:0]   dst_size;
    view_t         src_cur;
    view_t         dst_cur;
    logic [63:0]   cnt0;
    logic          covf0;
    logic [127:0]  cprod;
    logic          empty;
    view_final_t   se;
    view_final_t   de;
    status_t       st;
    logic [63:0]   sl;
    logic [63:0]   sh;
    logic [63:0]   dl;
    logic [63:0]   dh;

    first    = !in_layout_r;
    src_base = first ? s2_r.source_base          : src_base_r;
    dst_base = first ? s2_r.destination_base     : dst_base_r;
    src_size = first ? s2_r.source_capacity      : src_size_r;
    dst_size = first ? s2_r.destination_capacity : dst_size_r;

    src_cur.low  = first ? src_base : src_r.low;
    src_cur.high = first ? src_base : src_r.high;
    src_cur.err  = first ? (src_base[63] ? VERR_PRECEDES : VERR_NONE) : src_r.err;
    dst_cur.low  = first ? dst_base : dst_r.low;
    dst_cur.high = first ? dst_base : dst_r.high;
    dst_cur.err  = first ? (dst_base[63] ? VERR_PRECEDES : VERR_NONE) : dst_r.err;

    // Checked element count
    cnt0  = first ? 64'd1 : count_r;
    covf0 = first ? 1'b0  : covf_r;
    cprod = sum_products(part_products(cnt0, s2_r.extent));
    priority if (covf0) begin
      covf_nxt  = 1'b1;
      count_nxt = cnt0;
    end else if (cprod[127:64] != '0) begin
      covf_nxt  = 1'b1;
      count_nxt = cnt0;
    end else begin
      covf_nxt  = 1'b0;
      count_nxt = cprod[63:0];
    end

    src_nxt = view_step(src_cur, s2_r.skip, s2_r.src_neg, sum_products(s2_r.src_pp));
    dst_nxt = view_step(dst_cur, s2_r.skip, s2_r.dst_neg, sum_products(s2_r.dst_pp));

    // Final verdict: count, then source, then destination
    empty = (count_nxt == 64'd0);
    se    = view_final(empty, src_base, src_size, src_nxt);
    de    = view_final(empty, dst_base, dst_size, dst_nxt);
    priority if (covf_nxt) begin
      st = STAT_COUNT_OVF;
    end else if (se != VF_OK) begin
      unique case (se)
        VF_PRECEDES: st = STAT_SRC_PRECEDES;
        VF_OVERFLOW: st = STAT_SRC_OVERFLOW;
        default:     st = STAT_SRC_EXCEEDS;
      endcase
    end else if (de != VF_OK) begin
      unique case (de)
        VF_PRECEDES: st = STAT_DST_PRECEDES;
        VF_OVERFLOW: st = STAT_DST_OVERFLOW;
        default:     st = STAT_DST_EXCEEDS;
      endcase
    end else begin
      st = STAT_OK;
    end

    sl = empty ? src_base : src_nxt.low;
    sh = empty ? src_base : src_nxt.high;
    dl = empty ? dst_base : dst_nxt.low;
    dh = empty ? dst_base : dst_nxt.high;
    if (st != STAT_OK) begin
      sl = '0;
      sh = '0;
      dl = '0;
      dh = '0;
    end

    out_nxt.status              = st;
    out_nxt.source_lowest       = sl[62:0];
    out_nxt.source_highest      = sh[62:0];
    out_nxt.destination_lowest  = dl[62:0];
    out_nxt.destination_highest = dh[62:0];
    out_nxt.element_total       = covf_nxt ? 64'd0 : count_nxt;
  end

  // Hold the accumulators and the first-axis fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_layout_r <= 1'b0;
    end else if (fire3) begin
      in_layout_r <= !s2_r.last_axis;
    end
    if (fire3) begin
      count_r <= count_nxt;
      covf_r  <= covf_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      if (!in_layout_r) begin
        src_base_r <= s2_r.source_base;
        dst_base_r <= s2_r.destination_base;
        src_size_r <= s2_r.source_capacity;
        dst_size_r <= s2_r.destination_capacity;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire3 && s2_r.last_axis) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (fire3 && s2_r.last_axis) out_r <= out_nxt;
  end

  // A last axis waits in place while the result register is occupied
  a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_r.last_axis && !out_free |=> s2_v_r && $stable(s2_r))
    else $error("last axis left the accumulation stage while the result was blocked");

  // Any error clears all four bounds
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != STAT_OK |->
      out_r.source_lowest == '0 && out_r.source_highest == '0 &&
      out_r.destination_lowest == '0 && out_r.destination_highest == '0)
    else $error("bounds not cleared on an error status");

  // Count overflow clears the element total
  a_ovf_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == STAT_COUNT_OVF |-> out_r.element_total == '0)
    else $error("element total not cleared on count overflow");

  // A last axis closes the layout
  a_layout_close: assert property (@(posedge clk) disable iff (!rst_n)
    fire3 && s2_r.last_axis |=> !in_layout_r)
    else $error("layout still open after its last axis");

endmodule
